[hdl/ec2c_pkg.sv]
// Shared types, character codes and helper functions for the extended CIGAR to
// SAM CIGAR converter. Used by ec2c_ctrl, ec2c_dp and ecigar_to_cigar_converter_unit.
// No dependencies.
package ec2c_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int RUN_WIDTH_DEF  = 32;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_DIGIT,
    CLS_BASE,
    CLS_EQUAL,
    CLS_OPER,
    CLS_INVALID
  } char_class_e;

  typedef enum logic [2:0] {
    EMIT_RUN_DIGIT,
    EMIT_MATCH,
    EMIT_STORED,
    EMIT_OPER,
    EMIT_TERM
  } emit_sel_e;

  typedef struct packed {
    logic      set_err;
    logic      push_digit;
    logic      add_one;
    logic      add_value;
    logic      clear_digits;
    logic      clear_run;
    logic      clear_record;
    logic      conv_start;
    logic      conv_step;
    logic      run_shift;
    logic      dig_next;
    logic      emit;
    emit_sel_e sel;
    logic      emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    char_class_e cls;
    logic        eor;
    logic        err;
    logic        digit_full;
    logic        digit_empty;
    logic        run_zero;
    logic        step_last;
    logic        top_zero;
    logic        dig_last;
    logic        out_free;
  } dp_status_t;

  // decimal digits needed for 2^w - 1
  function automatic int dec_digits(int w);
    longint unsigned v;
    int n;
    v = (64'd1 << w) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        v = v / 64'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // bits needed for 10^d - 1
  function automatic int value_width(int d);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < d; i++) begin
      p = p * 64'd10;
    end
    return $clog2(p);
  endfunction

  function automatic char_class_e classify(logic [7:0] c);
    char_class_e r;
    case (c) inside
      CH_LBRACK, CH_LPAREN: r = CLS_SKIP;
      [CH_ZERO:CH_NINE]: r = CLS_DIGIT;
      CH_A, CH_C, CH_G, CH_T, CH_N: r = CLS_BASE;
      CH_EQUAL: r = CLS_EQUAL;
      CH_PLUS, CH_MINUS, CH_STAR, CH_RPAREN, CH_RBRACK, CH_PCT, CH_SLASH: r = CLS_OPER;
      default: r = CLS_INVALID;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] map_operator(logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_PLUS:   r = CH_I;
      CH_MINUS:  r = CH_D;
      CH_STAR:   r = CH_N;
      CH_RPAREN: r = CH_S;
      CH_RBRACK: r = CH_H;
      CH_PCT:    r = CH_N;
      CH_SLASH:  r = CH_N;
      default:   r = CH_NONE;
    endcase
    return r;
  endfunction

endpackage

[hdl/ec2c_dp.sv]
// Datapath of the converter: request capture, match run, digit buffer,
// binary to decimal converter and output register.
// Depends on ec2c_pkg.
module ec2c_dp #(
  parameter int MAX_DIGITS = ec2c_pkg::MAX_DIGITS_DEF,
  parameter int RUN_WIDTH  = ec2c_pkg::RUN_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             in_char_i,
  input  logic                   end_of_record_i,
  input  ec2c_pkg::ctrl_cmd_t    cmd_i,
  output ec2c_pkg::dp_status_t   st_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [7:0]             out_char_o,
  output logic                   has_char_o,
  output logic                   bad_token_o,
  output logic                   last_of_record_o
);

  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DV_W    = ec2c_pkg::value_width(MAX_DIGITS);
  localparam int AW      = (DV_W > RUN_WIDTH) ? DV_W : RUN_WIDTH;
  localparam int NUM_DIG = ec2c_pkg::dec_digits(RUN_WIDTH);
  localparam int BCD_W   = 4 * NUM_DIG;
  localparam int SC_W    = $clog2(RUN_WIDTH + 1);
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic [7:0]           char_q;
  logic                 eor_q;
  logic [RUN_WIDTH-1:0] run_q;
  logic                 err_q;
  logic [CNT_W-1:0]     digit_count_q;
  logic [DV_W-1:0]      digit_value_q;
  logic [3:0]           digit_store_q [MAX_DIGITS];
  logic [CNT_W-1:0]     dig_idx_q;
  logic [RUN_WIDTH-1:0] bin_q;
  logic [BCD_W-1:0]     bcd_q;
  logic [SC_W-1:0]      step_q;
  logic                 out_valid_q;
  logic [7:0]           out_char_q;
  logic                 has_char_q;
  logic                 bad_token_q;
  logic                 last_q;

  logic [RUN_WIDTH-1:0] diff;
  logic [AW-1:0]        amount;
  logic                 sat;
  logic [RUN_WIDTH-1:0] run_sum;
  logic [DV_W-1:0]      dv_next;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           top_digit;
  logic [3:0]           dig_rd;
  logic                 out_free;

  assign diff    = RUN_MAX - run_q;
  assign amount  = cmd_i.add_one ? AW'(1) : AW'(digit_value_q);
  assign sat     = amount >= AW'(diff);
  assign run_sum = sat ? RUN_MAX : run_q + amount[RUN_WIDTH-1:0];
  assign dv_next = (digit_value_q << 3) + (digit_value_q << 1) + DV_W'(char_q[3:0]);

  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign dig_rd    = digit_store_q[dig_idx_q[IDX_W-1:0]];
  assign out_free  = !out_valid_q || !out_stall_i;

  assign st_o.cls         = ec2c_pkg::classify(char_q);
  assign st_o.eor         = eor_q;
  assign st_o.err         = err_q;
  assign st_o.digit_full  = digit_count_q == CNT_W'(MAX_DIGITS);
  assign st_o.digit_empty = digit_count_q == '0;
  assign st_o.run_zero    = run_q == '0;
  assign st_o.step_last   = step_q == SC_W'(1);
  assign st_o.top_zero    = top_digit == 4'd0;
  assign st_o.dig_last    = (dig_idx_q + CNT_W'(1)) == digit_count_q;
  assign st_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q         <= '0;
      err_q         <= 1'b0;
      digit_count_q <= '0;
      digit_value_q <= '0;
      dig_idx_q     <= '0;
      step_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_record || cmd_i.clear_run) begin
        run_q <= '0;
      end else if (cmd_i.add_one || cmd_i.add_value) begin
        run_q <= run_sum;
      end

      if (cmd_i.clear_record) begin
        err_q <= 1'b0;
      end else if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end

      if (cmd_i.clear_record || cmd_i.clear_digits) begin
        digit_count_q <= '0;
        digit_value_q <= '0;
        dig_idx_q     <= '0;
      end else begin
        if (cmd_i.push_digit) begin
          digit_count_q <= digit_count_q + CNT_W'(1);
          digit_value_q <= dv_next;
        end
        if (cmd_i.dig_next) begin
          dig_idx_q <= dig_idx_q + CNT_W'(1);
        end
      end

      if (cmd_i.conv_start) begin
        step_q <= SC_W'(RUN_WIDTH);
      end else if (cmd_i.conv_step) begin
        step_q <= (step_q == SC_W'(1)) ? SC_W'(NUM_DIG) : step_q - SC_W'(1);
      end else if (cmd_i.run_shift) begin
        step_q <= step_q - SC_W'(1);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      char_q <= in_char_i;
      eor_q  <= end_of_record_i;
    end
    if (cmd_i.push_digit) begin
      digit_store_q[digit_count_q[IDX_W-1:0]] <= char_q[3:0];
    end
    if (cmd_i.conv_start) begin
      bin_q <= run_q;
      bcd_q <= '0;
    end else if (cmd_i.conv_step) begin
      bin_q <= bin_q << 1;
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[RUN_WIDTH-1]};
    end else if (cmd_i.run_shift) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
    end
    if (cmd_i.emit) begin
      case (cmd_i.sel)
        ec2c_pkg::EMIT_RUN_DIGIT: begin
          out_char_q  <= ec2c_pkg::CH_ZERO | {4'd0, top_digit};
          has_char_q  <= 1'b1;
          bad_token_q <= 1'b0;
          last_q      <= 1'b0;
        end
        ec2c_pkg::EMIT_MATCH: begin
          out_char_q  <= ec2c_pkg::CH_M;
          has_char_q  <= 1'b1;
          bad_token_q <= 1'b0;
          last_q      <= cmd_i.emit_last;
        end
        ec2c_pkg::EMIT_STORED: begin
          out_char_q  <= ec2c_pkg::CH_ZERO | {4'd0, dig_rd};
          has_char_q  <= 1'b1;
          bad_token_q <= 1'b0;
          last_q      <= 1'b0;
        end
        ec2c_pkg::EMIT_OPER: begin
          out_char_q  <= ec2c_pkg::map_operator(char_q);
          has_char_q  <= 1'b1;
          bad_token_q <= 1'b0;
          last_q      <= cmd_i.emit_last;
        end
        default: begin
          out_char_q  <= ec2c_pkg::CH_NONE;
          has_char_q  <= 1'b0;
          bad_token_q <= err_q;
          last_q      <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign has_char_o       = has_char_q;
  assign bad_token_o      = bad_token_q;
  assign last_of_record_o = last_q;

`ifndef NO_ASSERTIONS
  a_digit_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_count_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

  a_bad_is_terminator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_token_o |-> last_of_record_o && !has_char_o)
    else $error("error flag on a result that is not a bare terminator");
`endif

endmodule

[hdl/ec2c_ctrl.sv]
// Controller state machine of the converter: decodes each request and
// sequences run flush, digit echo, operator and terminator results.
// Depends on ec2c_pkg; drives ec2c_dp through ctrl_cmd_t.
module ec2c_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  ec2c_pkg::dp_status_t st_i,
  output ec2c_pkg::ctrl_cmd_t  cmd_o,
  output logic                 in_stall_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH_CHK,
    ST_CONV,
    ST_RUN_OUT,
    ST_EMIT_M,
    ST_DIG,
    ST_OP,
    ST_TERM
  } state_e;

  state_e state_q, state_d;
  logic   op_q, op_d;
  logic   started_q, started_d;
  logic   new_err;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    started_d = started_q;
    new_err   = 1'b0;
    cmd_o     = '0;
    cmd_o.sel = ec2c_pkg::EMIT_TERM;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        op_d = 1'b0;
        if (st_i.err) begin
          state_d = st_i.eor ? ST_TERM : ST_IDLE;
        end else begin
          case (st_i.cls)
            ec2c_pkg::CLS_DIGIT: begin
              if (st_i.digit_full) begin
                new_err = 1'b1;
              end else begin
                cmd_o.push_digit = 1'b1;
              end
            end
            ec2c_pkg::CLS_BASE: cmd_o.add_one = 1'b1;
            ec2c_pkg::CLS_EQUAL: begin
              if (st_i.digit_empty) begin
                new_err = 1'b1;
              end else begin
                cmd_o.add_value    = 1'b1;
                cmd_o.clear_digits = 1'b1;
              end
            end
            ec2c_pkg::CLS_OPER: op_d = 1'b1;
            ec2c_pkg::CLS_INVALID: new_err = 1'b1;
            default: ;
          endcase
          cmd_o.set_err = new_err;
          if (new_err) begin
            state_d = st_i.eor ? ST_TERM : ST_IDLE;
          end else if (st_i.cls == ec2c_pkg::CLS_OPER || st_i.eor) begin
            state_d = ST_FLUSH_CHK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH_CHK: begin
        if (!st_i.run_zero) begin
          cmd_o.conv_start = 1'b1;
          state_d          = ST_CONV;
        end else if (op_q) begin
          state_d = st_i.digit_empty ? ST_OP : ST_DIG;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        started_d       = 1'b0;
        if (st_i.step_last) begin
          state_d = ST_RUN_OUT;
        end
      end
      ST_RUN_OUT: begin
        if (!started_q && st_i.top_zero) begin
          cmd_o.run_shift = 1'b1;
          if (st_i.step_last) begin
            state_d = ST_EMIT_M;
          end
        end else if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = ec2c_pkg::EMIT_RUN_DIGIT;
          cmd_o.run_shift = 1'b1;
          started_d       = 1'b1;
          if (st_i.step_last) begin
            state_d = ST_EMIT_M;
          end
        end
      end
      ST_EMIT_M: begin
        if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = ec2c_pkg::EMIT_MATCH;
          cmd_o.emit_last = st_i.eor && !op_q;
          cmd_o.clear_run = 1'b1;
          if (op_q) begin
            state_d = st_i.digit_empty ? ST_OP : ST_DIG;
          end else begin
            cmd_o.clear_record = 1'b1;
            state_d            = ST_IDLE;
          end
        end
      end
      ST_DIG: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = ec2c_pkg::EMIT_STORED;
          cmd_o.dig_next = 1'b1;
          if (st_i.dig_last) begin
            state_d = ST_OP;
          end
        end
      end
      ST_OP: begin
        if (st_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.sel          = ec2c_pkg::EMIT_OPER;
          cmd_o.emit_last    = st_i.eor;
          cmd_o.clear_digits = 1'b1;
          cmd_o.clear_record = st_i.eor;
          state_d            = ST_IDLE;
        end
      end
      ST_TERM: begin
        if (st_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.sel          = ec2c_pkg::EMIT_TERM;
          cmd_o.clear_record = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= 1'b0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      started_q <= started_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

`ifndef NO_ASSERTIONS
  a_accept_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> state_q == ST_DECODE)
    else $error("accepted request not decoded next cycle");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> st_i.out_free)
    else $error("result loaded into an occupied output register");

  a_run_held_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN_OUT |-> !st_i.run_zero)
    else $error("match run lost during decimal output");
`endif

endmodule

[hdl/ecigar_to_cigar_converter_unit.sv]
// Top level of the extended CIGAR to SAM CIGAR converter.
// Depends on ec2c_pkg, ec2c_ctrl and ec2c_dp.
//
// Takes one extended CIGAR character per request and returns SAM CIGAR
// characters through an output register. Skipped characters, digits, base
// letters and '=' are accepted and then decoded. An operator or a clean
// record end also passes a flush check and then emits its results; when the
// match run is nonzero it first goes through a shift-add-3 binary to decimal
// converter, then the decimal digit positions of a RUN_WIDTH-bit value are
// shifted out in turn, with leading zeros shifted but not emitted.
// A stalled output holds these steps. Input is taken only between requests.
module ecigar_to_cigar_converter_unit #(
  parameter int MAX_DIGITS = ec2c_pkg::MAX_DIGITS_DEF,
  parameter int RUN_WIDTH  = ec2c_pkg::RUN_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_record_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       has_char_o,
  output logic       bad_token_o,
  output logic       last_of_record_o
);

  ec2c_pkg::ctrl_cmd_t  cmd;
  ec2c_pkg::dp_status_t st;
  logic                 accept;

  assign accept = in_valid_i && !in_stall_o;

  ec2c_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ec2c_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .RUN_WIDTH  (RUN_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .in_char_i        (in_char_i),
    .end_of_record_i  (end_of_record_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_char_o       (out_char_o),
    .has_char_o       (has_char_o),
    .bad_token_o      (bad_token_o),
    .last_of_record_o (last_of_record_o)
  );

endmodule
